// ===== src/nearest_seed_region_labeler_defines.svh =====
// Assertion macros used by the labeler top module.
`ifndef NEAREST_SEED_REGION_LABELER_DEFINES_SVH
`define NEAREST_SEED_REGION_LABELER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NSRL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nsrl same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define NSRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nsrl next-cycle check failed");

`endif

// ===== src/nsrl_pkg.sv =====
`default_nettype none

package nsrl_pkg;

    // Default sizing of the seed chain.
    localparam int NUM_SEEDS_DEF  = 16;
    localparam int COORD_BITS_DEF = 8;

    // Fixed field widths.
    localparam int MAP_W      = 8;
    localparam int COUNT_W    = 5;
    localparam int SLOT_W     = 4;
    localparam int REGION_W   = 4;
    localparam int LIMIT_W    = 2 * MAP_W + 1;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register reset values.
    localparam logic [MAP_W-1:0]   MAP_WIDTH_RESET  = 8'd160;
    localparam logic [MAP_W-1:0]   MAP_HEIGHT_RESET = 8'd90;
    localparam logic [COUNT_W-1:0] SEED_COUNT_RESET = 5'd16;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET      = LIMIT_W'(160 * 160 + 90 * 90);

    // Register indexes (word address on the APB port).
    typedef enum logic [1:0] {
        REG_MAP_WIDTH  = 2'd0,
        REG_MAP_HEIGHT = 2'd1,
        REG_SEED_COUNT = 2'd2
    } reg_index_t;

    // Item operation codes.
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_LABEL = 1'b1
    } op_t;

    // Control part of an item as it travels down the chain.
    typedef struct packed {
        logic                valid;
        logic                load;
        logic [SLOT_W-1:0]   slot;
        logic [REGION_W-1:0] region;
        logic                found;
    } ctl_t;

endpackage

`default_nettype wire

// ===== src/nsrl_if.sv =====
`default_nettype none

// Input item channel: seed loads and pixel labels.
interface nsrl_item_if #(
    parameter int COORD_BITS = nsrl_pkg::COORD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [nsrl_pkg::SLOT_W-1:0]   seed_index;
    logic [COORD_BITS-1:0]         coord_x;
    logic [COORD_BITS-1:0]         coord_y;

    modport source (output valid, operation, seed_index, coord_x, coord_y, input ready);
    modport sink   (input valid, operation, seed_index, coord_x, coord_y, output ready);
endinterface

// Result item channel: one label per pixel.
interface nsrl_result_if;
    logic                          valid;
    logic                          ready;
    logic [nsrl_pkg::REGION_W-1:0] region;
    logic                          unassigned;
    logic [nsrl_pkg::LIMIT_W-1:0]  best_distance_sq;

    modport source (output valid, region, unassigned, best_distance_sq, input ready);
    modport sink   (input valid, region, unassigned, best_distance_sq, output ready);
endinterface

`default_nettype wire

// ===== src/nearest_seed_region_labeler.sv =====
// Nearest-seed region labeler. Items enter on the item channel: a load item
// (operation 0) stores a seed in the slot given by seed_index and gives no
// result; a label item (operation 1) gives one result with the index of the
// nearest active seed and its exact squared distance, or the unassigned flag
// when no seed is strictly closer than the squared map diagonal. Each seed
// lives in one cell of a chain of NUM_SEEDS cells, and every item walks the
// chain one cell per cycle, so items are taken one per cycle unless the chain
// is stalled; the result register stalls the whole chain when the result is
// not taken. Loads travel the same chain, so each pixel sees exactly the seeds
// loaded before it. Write the registers only while no item is in flight; map
// size changes reach the limit in the cycle after the write.
`default_nettype none

`include "nearest_seed_region_labeler_defines.svh"

module nearest_seed_region_labeler #(
    parameter int NUM_SEEDS  = nsrl_pkg::NUM_SEEDS_DEF,
    parameter int COORD_BITS = nsrl_pkg::COORD_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [nsrl_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [nsrl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [nsrl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    nsrl_item_if.sink                              item,
    nsrl_result_if.source                          result
);

    localparam int DIST_W = (2 * COORD_BITS + 1 > nsrl_pkg::LIMIT_W)
                          ? 2 * COORD_BITS + 1 : nsrl_pkg::LIMIT_W;

    logic [nsrl_pkg::COUNT_W-1:0]  seed_count;
    logic [nsrl_pkg::LIMIT_W-1:0]  limit;
    logic                          advance;

    nsrl_pkg::ctl_t                ctl_chain  [NUM_SEEDS+1];
    logic [COORD_BITS-1:0]         x_chain    [NUM_SEEDS+1];
    logic [COORD_BITS-1:0]         y_chain    [NUM_SEEDS+1];
    logic [DIST_W-1:0]             best_chain [NUM_SEEDS+1];

    nsrl_pkg::ctl_t                head_ctl_reg;
    logic [COORD_BITS-1:0]         head_x_reg;
    logic [COORD_BITS-1:0]         head_y_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [nsrl_pkg::REGION_W-1:0] out_region_reg;
    logic                          out_unassigned_reg;
    logic [DIST_W-1:0]             out_best_reg;

    // Configuration registers and the squared-diagonal limit.
    nsrl_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .seed_count (seed_count),
        .limit      (limit)
    );

    // The chain moves whenever the result register is free or being emptied.
    assign advance    = !out_valid_reg || result.ready;
    assign item.ready = advance;

    // Head stage captures the accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ctl_reg <= '0;
        end
        else if (advance)
        begin
            head_ctl_reg.valid  <= item.valid;
            head_ctl_reg.load   <= (nsrl_pkg::op_t'(item.operation) == nsrl_pkg::OP_LOAD);
            head_ctl_reg.slot   <= item.seed_index;
            head_ctl_reg.region <= '0;
            head_ctl_reg.found  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            head_x_reg <= item.coord_x;
            head_y_reg <= item.coord_y;
        end
    end

    assign ctl_chain[0]  = head_ctl_reg;
    assign x_chain[0]    = head_x_reg;
    assign y_chain[0]    = head_y_reg;
    assign best_chain[0] = DIST_W'(limit);

    // One cell per seed slot.
    for (genvar j = 0; j < NUM_SEEDS; j++)
    begin : g_cell
        nsrl_cell #(
            .CELL_INDEX (j),
            .COORD_BITS (COORD_BITS),
            .DIST_W     (DIST_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .seed_count (seed_count),
            .ctl_in     (ctl_chain[j]),
            .x_in       (x_chain[j]),
            .y_in       (y_chain[j]),
            .best_in    (best_chain[j]),
            .ctl_out    (ctl_chain[j+1]),
            .x_out      (x_chain[j+1]),
            .y_out      (y_chain[j+1]),
            .best_out   (best_chain[j+1])
        );
    end

    // Result register: only label items leave the chain as results.
    assign out_valid_next = ctl_chain[NUM_SEEDS].valid && !ctl_chain[NUM_SEEDS].load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_region_reg     <= ctl_chain[NUM_SEEDS].region;
            out_unassigned_reg <= !ctl_chain[NUM_SEEDS].found;
            out_best_reg       <= best_chain[NUM_SEEDS];
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.region           = out_region_reg;
    assign result.unassigned       = out_unassigned_reg;
    assign result.best_distance_sq = out_best_reg[nsrl_pkg::LIMIT_W-1:0];

    // An unassigned pixel reports region zero and the limit itself.
    `NSRL_ASSERT_NOW(a_unassigned_region_zero, clk, rst_n, out_valid_reg && out_unassigned_reg, out_region_reg == '0)
    `NSRL_ASSERT_NOW(a_unassigned_is_limit, clk, rst_n, out_valid_reg && out_unassigned_reg, out_best_reg == DIST_W'(limit))
    // A winning distance never exceeds the starting limit.
    `NSRL_ASSERT_NOW(a_best_within_limit, clk, rst_n, out_valid_reg, out_best_reg <= DIST_W'(limit))
    // A load item leaving the chain produces no result.
    `NSRL_ASSERT_NEXT(a_load_no_result, clk, rst_n, advance && ctl_chain[NUM_SEEDS].valid && ctl_chain[NUM_SEEDS].load, !out_valid_reg)
    // A stall freezes the head of the chain.
    `NSRL_ASSERT_NEXT(a_stall_holds_head, clk, rst_n, !advance, $stable(head_ctl_reg))

endmodule

`default_nettype wire

// ===== src/nsrl_cfg.sv =====
`default_nettype none

module nsrl_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [nsrl_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [nsrl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [nsrl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output logic      [nsrl_pkg::COUNT_W-1:0]      seed_count,
    output logic      [nsrl_pkg::LIMIT_W-1:0]      limit
);

    logic [nsrl_pkg::MAP_W-1:0]   map_width_reg;
    logic [nsrl_pkg::MAP_W-1:0]   map_height_reg;
    logic [nsrl_pkg::COUNT_W-1:0] seed_count_reg;
    logic [nsrl_pkg::LIMIT_W-1:0] limit_reg;
    logic [nsrl_pkg::LIMIT_W-1:0] limit_next;
    logic [2*nsrl_pkg::MAP_W-1:0] width_sq;
    logic [2*nsrl_pkg::MAP_W-1:0] height_sq;
    nsrl_pkg::reg_index_t         reg_sel;
    logic                         write_en;

    assign pready   = 1'b1;
    assign reg_sel  = nsrl_pkg::reg_index_t'(paddr[3:2]);
    assign write_en = psel && penable && pwrite && pready;

    // Register writes; addresses past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= nsrl_pkg::MAP_WIDTH_RESET;
            map_height_reg <= nsrl_pkg::MAP_HEIGHT_RESET;
            seed_count_reg <= nsrl_pkg::SEED_COUNT_RESET;
        end
        else if (write_en)
        begin
            case (reg_sel)
                nsrl_pkg::REG_MAP_WIDTH:  map_width_reg  <= pwdata[nsrl_pkg::MAP_W-1:0];
                nsrl_pkg::REG_MAP_HEIGHT: map_height_reg <= pwdata[nsrl_pkg::MAP_W-1:0];
                nsrl_pkg::REG_SEED_COUNT: seed_count_reg <= pwdata[nsrl_pkg::COUNT_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Read-back mux.
    always_comb
    begin
        prdata = '0;
        case (reg_sel)
            nsrl_pkg::REG_MAP_WIDTH:  prdata = nsrl_pkg::APB_DATA_W'(map_width_reg);
            nsrl_pkg::REG_MAP_HEIGHT: prdata = nsrl_pkg::APB_DATA_W'(map_height_reg);
            nsrl_pkg::REG_SEED_COUNT: prdata = nsrl_pkg::APB_DATA_W'(seed_count_reg);
            default:                  prdata = '0;
        endcase
    end

    // The squared diagonal is kept in a register so the first cell sees it directly.
    assign width_sq   = {{nsrl_pkg::MAP_W{1'b0}}, map_width_reg}
                      * {{nsrl_pkg::MAP_W{1'b0}}, map_width_reg};
    assign height_sq  = {{nsrl_pkg::MAP_W{1'b0}}, map_height_reg}
                      * {{nsrl_pkg::MAP_W{1'b0}}, map_height_reg};
    assign limit_next = {1'b0, width_sq} + {1'b0, height_sq};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= nsrl_pkg::LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    assign seed_count = seed_count_reg;
    assign limit      = limit_reg;

endmodule

`default_nettype wire

// ===== src/nsrl_cell.sv =====
`default_nettype none

module nsrl_cell #(
    parameter int CELL_INDEX = 0,
    parameter int COORD_BITS = nsrl_pkg::COORD_BITS_DEF,
    parameter int DIST_W     = nsrl_pkg::LIMIT_W
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic [nsrl_pkg::COUNT_W-1:0]  seed_count,
    input  wire nsrl_pkg::ctl_t                ctl_in,
    input  wire logic [COORD_BITS-1:0]         x_in,
    input  wire logic [COORD_BITS-1:0]         y_in,
    input  wire logic [DIST_W-1:0]             best_in,
    output nsrl_pkg::ctl_t                     ctl_out,
    output logic      [COORD_BITS-1:0]         x_out,
    output logic      [COORD_BITS-1:0]         y_out,
    output logic      [DIST_W-1:0]             best_out
);

    logic [COORD_BITS-1:0]   seed_x_reg;
    logic [COORD_BITS-1:0]   seed_y_reg;
    nsrl_pkg::ctl_t          ctl_reg;
    nsrl_pkg::ctl_t          ctl_next;
    logic [COORD_BITS-1:0]   x_reg;
    logic [COORD_BITS-1:0]   y_reg;
    logic [DIST_W-1:0]       best_reg;
    logic [DIST_W-1:0]       best_next;
    logic [COORD_BITS-1:0]   dx;
    logic [COORD_BITS-1:0]   dy;
    logic [2*COORD_BITS-1:0] dx_sq;
    logic [2*COORD_BITS-1:0] dy_sq;
    logic [2*COORD_BITS:0]   dist_sq;
    logic                    slot_hit;
    logic                    active;
    logic                    closer;

    assign slot_hit = (32'(ctl_in.slot) == CELL_INDEX);
    assign active   = (32'(seed_count) > CELL_INDEX);

    // This cell's seed is written when a load item for its slot passes by.
    always_ff @(posedge clk)
    begin
        if (advance && ctl_in.valid && ctl_in.load && slot_hit)
        begin
            seed_x_reg <= x_in;
            seed_y_reg <= y_in;
        end
    end

    // Squared distance from the passing pixel to this cell's seed.
    assign dx      = (x_in >= seed_x_reg) ? (x_in - seed_x_reg) : (seed_x_reg - x_in);
    assign dy      = (y_in >= seed_y_reg) ? (y_in - seed_y_reg) : (seed_y_reg - y_in);
    assign dx_sq   = {{COORD_BITS{1'b0}}, dx} * {{COORD_BITS{1'b0}}, dx};
    assign dy_sq   = {{COORD_BITS{1'b0}}, dy} * {{COORD_BITS{1'b0}}, dy};
    assign dist_sq = {1'b0, dx_sq} + {1'b0, dy_sq};

    // Strictly closer seeds win, so the lowest index keeps a tie.
    always_comb
    begin
        closer    = ctl_in.valid && !ctl_in.load && active && (DIST_W'(dist_sq) < best_in);
        ctl_next  = ctl_in;
        best_next = best_in;
        if (closer)
        begin
            ctl_next.region = nsrl_pkg::REGION_W'(CELL_INDEX);
            ctl_next.found  = 1'b1;
            best_next       = DIST_W'(dist_sq);
        end
    end

    // Hand the item on to the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg    <= x_in;
            y_reg    <= y_in;
            best_reg <= best_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign best_out = best_reg;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import nsrl_pkg::*;

    localparam int NUM_SEEDS     = NUM_SEEDS_DEF;
    localparam int COORD_BITS    = COORD_BITS_DEF;
    // A label passes the head register and every seed cell before it leaves the chain.
    localparam int SETTLE_CYCLES = NUM_SEEDS + 8;
    localparam int RUN_LIMIT     = 400000;
    localparam int HOLDOFF_AT    = 200;
    localparam int HOLDOFF_LEN   = 400;
    localparam int MAX_PRINTED   = 40;

    // One input item: a seed load or a pixel to be labeled.
    typedef struct packed {
        op_t                   op;
        logic [SLOT_W-1:0]     slot;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } map_item_t;

    // One label result.
    typedef struct packed {
        logic [REGION_W-1:0] region;
        logic                unassigned;
        logic [LIMIT_W-1:0]  best_sq;
    } label_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    nsrl_item_if #(.COORD_BITS(COORD_BITS)) item_ch();
    nsrl_result_if                          result_ch();

    nearest_seed_region_labeler #(
        .NUM_SEEDS  (NUM_SEEDS),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_ch),
        .result  (result_ch)
    );

    // Shadow copy of the registers and the seed table.
    logic [MAP_W-1:0]      cfg_map_width;
    logic [MAP_W-1:0]      cfg_map_height;
    logic [COUNT_W-1:0]    cfg_seed_count;
    logic [COORD_BITS-1:0] seed_x [NUM_SEEDS];
    logic [COORD_BITS-1:0] seed_y [NUM_SEEDS];

    map_item_t pending_items [$];
    label_t    expected_labels [$];

    int        items_queued = 0;
    int        items_accepted;
    int        error_count = 0;
    int        cycle_count = 0;
    int        burst_left;
    int        gap_left;
    int        holdoff_left;
    logic      holdoff_done;
    int        stall_mode;
    logic [7:0] stall_pattern;
    map_item_t on_bus;
    label_t    want;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Item and result channel inputs are known from time zero.
    initial
    begin
        item_ch.valid      = 1'b0;
        item_ch.operation  = OP_LOAD;
        item_ch.seed_index = '0;
        item_ch.coord_x    = '0;
        item_ch.coord_y    = '0;
        result_ch.ready    = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTED)
        begin
            $display("ERROR at %0t: %s", $time, what);
        end
        error_count++;
    endtask

    function automatic int active_seeds();
        return (cfg_seed_count > NUM_SEEDS) ? NUM_SEEDS : int'(cfg_seed_count);
    endfunction

    // Apply one accepted item: loads update the seed table, pixels get a label.
    function automatic void predict_nearest_seed(input map_item_t it);
        logic [LIMIT_W-1:0]    best;
        logic [LIMIT_W-1:0]    d;
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        logic [REGION_W-1:0]   winner;
        logic                  found;
        label_t                lbl;
        if (it.op == OP_LOAD)
        begin
            seed_x[it.slot] = it.x;
            seed_y[it.slot] = it.y;
            return;
        end
        best   = LIMIT_W'(cfg_map_width) * LIMIT_W'(cfg_map_width)
               + LIMIT_W'(cfg_map_height) * LIMIT_W'(cfg_map_height);
        winner = '0;
        found  = 1'b0;
        for (int j = 0; j < active_seeds(); j++)
        begin
            dx = (it.x >= seed_x[j]) ? it.x - seed_x[j] : seed_x[j] - it.x;
            dy = (it.y >= seed_y[j]) ? it.y - seed_y[j] : seed_y[j] - it.y;
            d  = LIMIT_W'(dx) * LIMIT_W'(dx) + LIMIT_W'(dy) * LIMIT_W'(dy);
            // Strictly closer only, so the lowest index keeps a tie.
            if (d < best)
            begin
                best   = d;
                winner = REGION_W'(j);
                found  = 1'b1;
            end
        end
        lbl.region     = found ? winner : '0;
        lbl.unassigned = !found;
        lbl.best_sq    = best;
        expected_labels.push_back(lbl);
    endfunction

    // Item driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid  <= 1'b0;
            items_accepted <= 0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                predict_nearest_seed(on_bus);
                items_accepted <= items_accepted + 1;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (gap_left > 0 || pending_items.size() == 0)
                begin
                    if (gap_left > 0)
                    begin
                        gap_left--;
                    end
                    item_ch.valid <= 1'b0;
                end
                else
                begin
                    on_bus = pending_items.pop_front();
                    item_ch.valid      <= 1'b1;
                    item_ch.operation  <= on_bus.op;
                    item_ch.seed_index <= on_bus.slot;
                    item_ch.coord_x    <= on_bus.x;
                    item_ch.coord_y    <= on_bus.y;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 48);
                        case ($urandom_range(19))
                            0:             gap_left = $urandom_range(11, 24);
                            1, 2, 3, 4, 5: gap_left = $urandom_range(4, 10);
                            default:       gap_left = $urandom_range(0, 3);
                        endcase
                    end
                end
            end
        end
    end

    // One long receiver hold-off while the sender keeps offering items.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_left <= 0;
            holdoff_done <= 1'b0;
        end
        else if (!holdoff_done && items_accepted >= HOLDOFF_AT)
        begin
            holdoff_left <= HOLDOFF_LEN;
            holdoff_done <= 1'b1;
        end
        else if (holdoff_left > 0)
        begin
            holdoff_left <= holdoff_left - 1;
        end
    end

    // Result monitor and receiver stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_mode    = 0;
            stall_pattern = 8'hFF;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_labels.size() == 0)
                begin
                    report_mismatch("label arrived with none pending");
                end
                else
                begin
                    want = expected_labels.pop_front();
                    if (result_ch.region !== want.region)
                    begin
                        report_mismatch($sformatf("region got %0d expected %0d",
                            result_ch.region, want.region));
                    end
                    if (result_ch.unassigned !== want.unassigned)
                    begin
                        report_mismatch($sformatf("unassigned got %0b expected %0b",
                            result_ch.unassigned, want.unassigned));
                    end
                    if (result_ch.best_distance_sq !== want.best_sq)
                    begin
                        report_mismatch($sformatf("best_distance_sq got %0d expected %0d",
                            result_ch.best_distance_sq, want.best_sq));
                    end
                end
            end
            if (cycle_count % 128 == 0)
            begin
                stall_mode    = $urandom_range(2);
                stall_pattern = 8'($urandom) | 8'h01;
            end
            else
            begin
                stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
            end
            if (holdoff_left > 0)
            begin
                result_ch.ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= stall_pattern[0];
                    default: result_ch.ready <= ($urandom_range(3) == 0);
                endcase
            end
        end
    end

    task automatic write_register(input reg_index_t idx, input logic [APB_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MAP_WIDTH:  cfg_map_width  = value[MAP_W-1:0];
            REG_MAP_HEIGHT: cfg_map_height = value[MAP_W-1:0];
            REG_SEED_COUNT: cfg_seed_count = value[COUNT_W-1:0];
            default:        ;
        endcase
    endtask

    task automatic queue_item(input op_t op, input int slot, input int x, input int y);
        map_item_t it;
        it.op   = op;
        it.slot = SLOT_W'(slot);
        it.x    = COORD_BITS'(x);
        it.y    = COORD_BITS'(y);
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Mostly pixels inside the map, some anywhere, some in a tight cluster
    // of even seed points with pixels in between to force ties.
    task automatic queue_random(input int count);
        int   kind;
        int   act;
        op_t  op;
        int   slot;
        for (int n = 0; n < count; n++)
        begin
            act  = active_seeds();
            op   = ($urandom_range(99) < 72) ? OP_LABEL : OP_LOAD;
            slot = (act > 0 && $urandom_range(3) != 0) ? $urandom_range(act - 1)
                                                        : $urandom_range(15);
            kind = $urandom_range(9);
            if (kind < 6)
            begin
                queue_item(op, slot, $urandom_range(cfg_map_width),
                           $urandom_range(cfg_map_height));
            end
            else if (kind < 8)
            begin
                queue_item(op, slot, $urandom_range(255), $urandom_range(255));
            end
            else if (op == OP_LOAD)
            begin
                queue_item(op, slot, 120 + 2 * $urandom_range(3), 60 + 2 * $urandom_range(3));
            end
            else
            begin
                queue_item(op, slot, 120 + $urandom_range(6), 60 + $urandom_range(6));
            end
        end
    endtask

    // Wait until every item is in, every label is out, and the chain is empty.
    task automatic wait_idle();
        do @(posedge clk);
        while (items_accepted != items_queued || expected_labels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Map size is written before the seed count, so the new limit has
    // settled by the time the first item of the phase can enter.
    task automatic run_phase(input int w, input int h, input int cnt, input int count);
        wait_idle();
        write_register(REG_MAP_WIDTH, APB_DATA_W'(w));
        write_register(REG_MAP_HEIGHT, APB_DATA_W'(h));
        write_register(REG_SEED_COUNT, APB_DATA_W'(cnt));
        queue_random(count);
    endtask

    initial
    begin
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        rst_n   = 1'b0;
        cfg_map_width  = MAP_WIDTH_RESET;
        cfg_map_height = MAP_HEIGHT_RESET;
        cfg_seed_count = SEED_COUNT_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Fill every slot before any pixel, at the reset map size.
        queue_item(OP_LOAD, 0, 0, 0);
        queue_item(OP_LOAD, 1, 255, 255);
        queue_item(OP_LOAD, 2, 255, 0);
        queue_item(OP_LOAD, 3, 0, 255);
        queue_item(OP_LOAD, 4, 80, 45);
        queue_item(OP_LOAD, 5, 80, 45);
        queue_item(OP_LOAD, 6, 100, 40);
        queue_item(OP_LOAD, 7, 104, 40);
        queue_item(OP_LOAD, 8, 8'hAA, 8'h55);
        queue_item(OP_LOAD, 9, 8'h55, 8'hAA);
        for (int i = 10; i < NUM_SEEDS; i++)
        begin
            queue_item(OP_LOAD, i, 20 * i - 150, 200 - 10 * i);
        end
        // Corners, duplicate seeds, an equidistant pair, and pixels off the map.
        queue_item(OP_LABEL, 0, 0, 0);
        queue_item(OP_LABEL, 15, 255, 255);
        queue_item(OP_LABEL, 0, 80, 45);
        queue_item(OP_LABEL, 0, 102, 40);
        queue_item(OP_LABEL, 0, 200, 100);
        queue_item(OP_LABEL, 0, 8'hAA, 8'hAA);
        queue_item(OP_LABEL, 0, 8'h55, 8'h55);
        queue_item(OP_LABEL, 0, 159, 89);
        queue_random(500);

        run_phase(255, 255, 16, 250);
        // Tiny map: almost every pixel stays unassigned.
        run_phase(1, 1, 1, 150);
        // No active seed at all.
        run_phase(255, 1, 0, 100);
        // Seed count beyond the table saturates.
        run_phase(1, 255, 31, 200);
        run_phase(7, 3, 5, 200);
        run_phase($urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(0, 31), 175);
        run_phase($urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(0, 31), 175);

        wait_idle();
        if (error_count == 0)
        begin
            $display("PASS nearest_seed_region_labeler");
        end
        else
        begin
            $display("FAIL nearest_seed_region_labeler");
        end
        $finish;
    end

    initial
    begin
        wait (cycle_count >= RUN_LIMIT);
        $display("FAIL nearest_seed_region_labeler");
        $finish;
    end

endmodule
